// File: design/row_by_matrix_multiply_macros.svh
// assertion macros for the row by matrix multiply checker
`ifndef ROW_BY_MATRIX_MULTIPLY_MACROS_SVH
`define ROW_BY_MATRIX_MULTIPLY_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define RBMM_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rbmm check failed");

// next-cycle implication, sampled on clk, off during reset
`define RBMM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rbmm check failed");

`endif

// File: design/rbmm_pkg.sv
// shared types and codes for the row by matrix multiply block
package rbmm_pkg;

  localparam logic CMD_LOAD   = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  localparam logic CFG_INNER_LENGTH   = 1'b0;
  localparam logic CFG_OUTPUT_COLUMNS = 1'b1;

  localparam int ROW_BITS = 6;
  localparam int COL_BITS = 4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAC,
    ST_DRAIN,
    ST_EMIT_RD,
    ST_EMIT_LD
  } rbmm_state_t;

  typedef struct packed {
    logic                coef_wr;
    logic                sample_ld;
    logic                mac_issue;
    logic                acc_rd;
    logic                out_ld;
    logic                acc_clr;
    logic                last_col;
    logic [ROW_BITS-1:0] row;
    logic [COL_BITS-1:0] col;
  } rbmm_cmd_t;

  typedef struct packed {
    logic pipe_busy;
    logic out_free;
  } rbmm_stat_t;

endpackage

// File: design/rbmm_in_if.sv
// input channel: coefficient loads and row elements
interface rbmm_in_if;
  logic               valid;
  logic               ready;
  logic               cmd;
  logic [3:0]         coef_inner;
  logic [3:0]         coef_column;
  logic signed [31:0] operand;

  modport source (output valid, cmd, coef_inner, coef_column, operand, input ready);
  modport sink   (input valid, cmd, coef_inner, coef_column, operand, output ready);
endinterface

// File: design/rbmm_out_if.sv
// result channel: one product sum per output column
interface rbmm_out_if;
  logic               valid;
  logic               ready;
  logic [3:0]         out_column;
  logic signed [63:0] product_sum;
  logic               last;

  modport source (output valid, out_column, product_sum, last, input ready);
  modport sink   (input valid, out_column, product_sum, last, output ready);
endinterface

// File: design/rbmm_ctrl.sv
// controller: configuration registers, element count and sequencing state machine
module rbmm_ctrl import rbmm_pkg::*; #(
  parameter int MAX_INNER   = 16,
  parameter int MAX_COLUMNS = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [4:0] cfg_wdata,
  input  logic       in_valid,
  input  logic       in_cmd,
  output logic       in_ready,
  input  rbmm_stat_t stat,
  output rbmm_cmd_t  cmd
);

  localparam int CNTW = $clog2(MAX_INNER + 1);

  rbmm_state_t         state_r, state_nxt;
  logic [4:0]          inner_length_r, output_columns_r;
  logic [CNTW-1:0]     count_r, count_nxt;
  logic [COL_BITS-1:0] col_r, col_nxt;
  logic [6:0]          eff_inner;
  logic [4:0]          eff_cols;
  logic [6:0]          cols_tmp;
  logic                last_col;
  logic                row_done;
  logic                in_xfer;

  always_comb begin
    eff_inner = 7'(inner_length_r);
    if (eff_inner == 7'd0) begin
      eff_inner = 7'd1;
    end
    if (eff_inner > 7'(MAX_INNER)) begin
      eff_inner = 7'(MAX_INNER);
    end
    cols_tmp = 7'(output_columns_r);
    if (cols_tmp == 7'd0) begin
      cols_tmp = 7'd1;
    end
    if (cols_tmp > 7'(MAX_COLUMNS)) begin
      cols_tmp = 7'(MAX_COLUMNS);
    end
    if (cols_tmp > 7'd16) begin
      cols_tmp = 7'd16;
    end
    eff_cols = 5'(cols_tmp);
  end

  assign last_col = (5'(col_r) + 5'd1) == eff_cols;
  assign row_done = (7'(count_r) + 7'd1) >= eff_inner;
  assign in_ready = (state_r == ST_IDLE);
  assign in_xfer  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inner_length_r   <= 5'd1;
      output_columns_r <= 5'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_INNER_LENGTH:   inner_length_r   <= cfg_wdata;
        CFG_OUTPUT_COLUMNS: output_columns_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    col_nxt   = col_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer && in_cmd == CMD_SAMPLE) begin
          state_nxt = ST_MAC;
          col_nxt   = '0;
        end
      end
      ST_MAC: begin
        if (last_col) begin
          state_nxt = ST_DRAIN;
        end else begin
          col_nxt = col_r + 1'b1;
        end
      end
      ST_DRAIN: begin
        if (!stat.pipe_busy) begin
          if (row_done) begin
            state_nxt = ST_EMIT_RD;
            col_nxt   = '0;
          end else begin
            state_nxt = ST_IDLE;
            count_nxt = count_r + 1'b1;
          end
        end
      end
      ST_EMIT_RD: begin
        state_nxt = ST_EMIT_LD;
      end
      ST_EMIT_LD: begin
        if (stat.out_free) begin
          if (last_col) begin
            state_nxt = ST_IDLE;
            count_nxt = '0;
          end else begin
            state_nxt = ST_EMIT_RD;
            col_nxt   = col_r + 1'b1;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // command outputs
  always_comb begin
    cmd          = '0;
    cmd.row      = ROW_BITS'(count_r);
    cmd.col      = col_r;
    cmd.last_col = last_col;
    unique case (state_r)
      ST_IDLE: begin
        cmd.coef_wr   = in_xfer && in_cmd == CMD_LOAD;
        cmd.sample_ld = in_xfer && in_cmd == CMD_SAMPLE;
      end
      ST_MAC:     cmd.mac_issue = 1'b1;
      ST_DRAIN:   ;
      ST_EMIT_RD: cmd.acc_rd = 1'b1;
      ST_EMIT_LD: begin
        cmd.out_ld  = stat.out_free;
        cmd.acc_clr = stat.out_free && last_col;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      count_r <= '0;
      col_r   <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      col_r   <= col_nxt;
    end
  end

endmodule

// File: design/rbmm_datapath.sv
// datapath: coefficient store, accumulator store, multiply-accumulate pipe, result register
module rbmm_datapath import rbmm_pkg::*; #(
  parameter int MAX_INNER   = 16,
  parameter int MAX_COLUMNS = 16,
  parameter int DATA_WIDTH  = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  rbmm_cmd_t          cmd,
  input  logic [3:0]         coef_inner,
  input  logic [3:0]         coef_column,
  input  logic signed [31:0] operand,
  output rbmm_stat_t         stat,
  input  logic               out_ready,
  output logic               out_valid,
  output logic [3:0]         out_column,
  output logic signed [63:0] product_sum,
  output logic               last
);

  localparam int DEPTH = MAX_INNER * MAX_COLUMNS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int PW    = 2 * DATA_WIDTH;

  logic signed [DATA_WIDTH-1:0] coef_mem [DEPTH];
  logic signed [63:0]           acc_mem  [MAX_COLUMNS];
  logic [MAX_COLUMNS-1:0]       acc_vld_r;

  logic signed [DATA_WIDTH-1:0] sample_r;
  logic signed [DATA_WIDTH-1:0] coef_q_r;
  logic signed [63:0]           acc_q_r;
  logic                         accv_q_r;
  logic                         p1_r, p2_r;
  logic [CW-1:0]                p1_col_r, p2_col_r;
  logic signed [PW-1:0]         prod_r;
  logic signed [63:0]           p2_acc_r;
  logic                         out_valid_r;
  logic [3:0]                   out_column_r;
  logic signed [63:0]           out_sum_r;
  logic                         out_last_r;

  logic [15:0]                  wr_addr_w, rd_addr_w;
  logic                         wr_in_range;
  logic [CW-1:0]                acc_col;
  logic signed [63:0]           acc_rd_val;
  logic signed [64:0]           sum_w;
  logic signed [63:0]           sat_w;

  assign wr_addr_w   = 16'(coef_inner) * 16'(MAX_COLUMNS) + 16'(coef_column);
  assign rd_addr_w   = 16'(cmd.row) * 16'(MAX_COLUMNS) + 16'(cmd.col);
  assign wr_in_range = (32'(coef_inner) < MAX_INNER) && (32'(coef_column) < MAX_COLUMNS);
  assign acc_col     = CW'(cmd.col);
  assign acc_rd_val  = accv_q_r ? acc_q_r : 64'sd0;

  // saturating accumulate
  always_comb begin
    sum_w = 65'(p2_acc_r) + 65'(64'(prod_r));
    if (sum_w[64] != sum_w[63]) begin
      sat_w = sum_w[64] ? {1'b1, {63{1'b0}}} : {1'b0, {63{1'b1}}};
    end else begin
      sat_w = sum_w[63:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.coef_wr && wr_in_range) begin
      coef_mem[wr_addr_w[AW-1:0]] <= $signed(operand[DATA_WIDTH-1:0]);
    end
    if (cmd.mac_issue) begin
      coef_q_r <= coef_mem[rd_addr_w[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (p2_r) begin
      acc_mem[p2_col_r] <= sat_w;
    end
    if (cmd.mac_issue || cmd.acc_rd) begin
      acc_q_r  <= acc_mem[acc_col];
      accv_q_r <= acc_vld_r[acc_col];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_vld_r <= '0;
    end else if (cmd.acc_clr) begin
      acc_vld_r <= '0;
    end else if (p2_r) begin
      acc_vld_r[p2_col_r] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sample_ld) begin
      sample_r <= $signed(operand[DATA_WIDTH-1:0]);
    end
    p1_col_r <= acc_col;
    p2_col_r <= p1_col_r;
    prod_r   <= sample_r * coef_q_r;
    p2_acc_r <= acc_rd_val;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_r <= 1'b0;
      p2_r <= 1'b0;
    end else begin
      p1_r <= cmd.mac_issue;
      p2_r <= p1_r;
    end
  end

  // result register, held until transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_ld) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_ld) begin
      out_column_r <= cmd.col;
      out_sum_r    <= acc_rd_val;
      out_last_r   <= cmd.last_col;
    end
  end

  assign stat.pipe_busy = p1_r || p2_r;
  assign stat.out_free  = !out_valid_r || out_ready;

  assign out_valid   = out_valid_r;
  assign out_column  = out_column_r;
  assign product_sum = out_sum_r;
  assign last        = out_last_r;

endmodule

// File: design/row_by_matrix_multiply.sv
// top level of the row by matrix multiply block
// Multiplies a streamed left-matrix row by a stored coefficient matrix in signed Q16.16,
// accumulating per output column in saturating Q32.32. A load transfer (cmd 0) writes one
// coefficient. A row element transfer (cmd 1) occupies the block while one shared multiplier
// walks the columns one per cycle through the coefficient and accumulator memories and then
// while the multiply-accumulate pipe drains. At row end each column result is read through the
// single accumulator read port and then loaded into the output register once that is free; the
// next input is taken while the last result waits. Accumulators are cleared at once through
// per-column valid bits, so no clearing pass runs after reset. The coefficient store is
// undefined until written.
module row_by_matrix_multiply import rbmm_pkg::*; #(
  parameter int MAX_INNER   = 16,
  parameter int MAX_COLUMNS = 16,
  parameter int DATA_WIDTH  = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [4:0]  cfg_wdata,
  rbmm_in_if.sink     in_chan,
  rbmm_out_if.source  out_chan
);

  rbmm_cmd_t  cmd;
  rbmm_stat_t stat;

  rbmm_ctrl #(
    .MAX_INNER   (MAX_INNER),
    .MAX_COLUMNS (MAX_COLUMNS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_chan.valid),
    .in_cmd    (in_chan.cmd),
    .in_ready  (in_chan.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  rbmm_datapath #(
    .MAX_INNER   (MAX_INNER),
    .MAX_COLUMNS (MAX_COLUMNS),
    .DATA_WIDTH  (DATA_WIDTH)
  ) u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .coef_inner  (in_chan.coef_inner),
    .coef_column (in_chan.coef_column),
    .operand     (in_chan.operand),
    .stat        (stat),
    .out_ready   (out_chan.ready),
    .out_valid   (out_chan.valid),
    .out_column  (out_chan.out_column),
    .product_sum (out_chan.product_sum),
    .last        (out_chan.last)
  );

endmodule

// File: design/rbmm_checker.sv
// port-level checks for the row by matrix multiply block, with bind
`include "row_by_matrix_multiply_macros.svh"

module rbmm_checker import rbmm_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               in_cmd,
  input logic               out_valid,
  input logic               out_ready,
  input logic [3:0]         out_column,
  input logic signed [63:0] product_sum,
  input logic               last
);

  // stalled result holds
  `RBMM_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_column) && $stable(product_sum) && $stable(last))

  // while a row is still being emitted no new input is taken
  `RBMM_ASSERT_NOW(a_emit_blocks_input, out_valid && !last, !in_ready)

  // a coefficient load leaves the block ready
  `RBMM_ASSERT_NEXT(a_load_stays_ready, in_valid && in_ready && in_cmd == CMD_LOAD, in_ready)

  // a row element keeps the block busy
  `RBMM_ASSERT_NEXT(a_sample_busy, in_valid && in_ready && in_cmd == CMD_SAMPLE, !in_ready)

endmodule

bind row_by_matrix_multiply rbmm_checker u_rbmm_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_chan.valid),
  .in_ready    (in_chan.ready),
  .in_cmd      (in_chan.cmd),
  .out_valid   (out_chan.valid),
  .out_ready   (out_chan.ready),
  .out_column  (out_chan.out_column),
  .product_sum (out_chan.product_sum),
  .last        (out_chan.last)
);
